/* rtl/prri_pkg.sv */
// Shared types and constants for the palette register and raster interrupt block.
// Used by prri_raster and the top level; depends on nothing.
`default_nettype none

package prri_pkg;

    localparam int PEN_COUNT     = 16;
    localparam int LINES_PER_INT = 52;

    localparam int PEN_IDX_W  = (PEN_COUNT > 1) ? $clog2(PEN_COUNT) : 1;
    localparam int COLOUR_W   = 5;
    localparam int MODE_W     = 2;
    localparam int LINE_W     = 6;
    localparam int RESYNC_W   = 5;
    localparam int MCLK_W     = 4;

    localparam logic [LINE_W-1:0]   LINES_WRAP   = LINE_W'(LINES_PER_INT);
    localparam logic [RESYNC_W-1:0] RESYNC_START = RESYNC_W'(2);
    localparam logic [RESYNC_W-1:0] RESYNC_LIMIT = RESYNC_W'(28);
    localparam logic [RESYNC_W-1:0] RESYNC_CLEAR = RESYNC_W'(4);
    localparam logic [MCLK_W-1:0]   MCLK_RESET   = MCLK_W'(2);
    localparam logic [MCLK_W-1:0]   MCLK_FIRE    = MCLK_W'(8);
    localparam logic [COLOUR_W-1:0] BORDER_RESET = COLOUR_W'(16);

    typedef enum logic [1:0] {
        FUNC_WRITE = 2'd0,
        FUNC_ACK   = 2'd1,
        FUNC_TICK  = 2'd2
    } prri_func_t;

    typedef enum logic [1:0] {
        WR_PEN_SEL  = 2'd0,
        WR_COLOUR   = 2'd1,
        WR_MODE_ROM = 2'd2,
        WR_MEM_MAP  = 2'd3
    } prri_wr_t;

    // one beat held in the input register
    typedef struct packed {
        logic       valid;
        prri_func_t func;
        logic [7:0] data;
        logic       m1_n;
        logic       iorq_n;
        logic       hsync;
        logic       vsync;
    } prri_step_t;

    typedef struct packed {
        logic              int_asserted;
        logic [MODE_W-1:0] active_mode;
        logic [LINE_W-1:0] line_counter;
    } prri_raster_t;

endpackage

`default_nettype wire

/* rtl/prri_raster.sv */
// Raster interrupt counter, acknowledge handling and hsync-timed mode latch.
// Depends on prri_pkg.
`default_nettype none

module prri_raster (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire prri_pkg::prri_step_t       step,
    input  wire logic [prri_pkg::MODE_W-1:0] pending_mode,
    output prri_pkg::prri_raster_t          status
);
    import prri_pkg::*;

    logic                int_reg,    int_next;
    logic [MODE_W-1:0]   mode_reg,   mode_next;
    logic [LINE_W-1:0]   line_reg,   line_next;
    logic [RESYNC_W-1:0] resync_reg, resync_next;
    logic                ack_reg,    ack_next;
    logic [MCLK_W-1:0]   mclk_reg,   mclk_next;
    logic                trig_reg,   trig_next;
    logic                hs_prev_reg, hs_prev_next;
    logic                vs_prev_reg, vs_prev_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            int_reg     <= 1'b0;
            mode_reg    <= '0;
            line_reg    <= '0;
            resync_reg  <= '0;
            ack_reg     <= 1'b0;
            mclk_reg    <= MCLK_RESET;
            trig_reg    <= 1'b0;
            hs_prev_reg <= 1'b0;
            vs_prev_reg <= 1'b0;
        end
        else
        begin
            int_reg     <= int_next;
            mode_reg    <= mode_next;
            line_reg    <= line_next;
            resync_reg  <= resync_next;
            ack_reg     <= ack_next;
            mclk_reg    <= mclk_next;
            trig_reg    <= trig_next;
            hs_prev_reg <= hs_prev_next;
            vs_prev_reg <= vs_prev_next;
        end
    end

    always_comb
    begin
        logic [LINE_W-1:0] line_inc;
        logic              m1_low;
        logic              iorq_low;

        int_next     = int_reg;
        mode_next    = mode_reg;
        line_next    = line_reg;
        resync_next  = resync_reg;
        ack_next     = ack_reg;
        mclk_next    = mclk_reg;
        trig_next    = trig_reg;
        hs_prev_next = hs_prev_reg;
        vs_prev_next = vs_prev_reg;
        line_inc     = line_reg + LINE_W'(1);
        m1_low       = !step.m1_n;
        iorq_low     = !step.iorq_n;

        if (step.valid)
        begin
            unique case (step.func)
                FUNC_WRITE:
                begin
                    // interrupt-delay reset rides on the mode/ROM write
                    if (step.data[7:6] == WR_MODE_ROM && step.data[4])
                    begin
                        int_next  = 1'b0;
                        line_next = '0;
                    end
                end
                FUNC_ACK:
                begin
                    if (m1_low && iorq_low && int_reg)
                        ack_next = 1'b1;
                    else if (!m1_low)
                        ack_next = 1'b0;
                    if (ack_next)
                    begin
                        line_next = {1'b0, line_reg[LINE_W-2:0]};
                        int_next  = 1'b0;
                    end
                end
                FUNC_TICK:
                begin
                    if (step.vsync && !vs_prev_reg)
                        resync_next = RESYNC_START;

                    if (!step.hsync && hs_prev_reg)
                    begin
                        line_next = (line_inc == LINES_WRAP) ? '0 : line_inc;
                        if (resync_next < RESYNC_LIMIT)
                        begin
                            resync_next = resync_next + RESYNC_W'(1);
                            if (resync_next == RESYNC_CLEAR)
                                line_next = '0;
                        end
                        if (line_next == '0 && line_reg[LINE_W-1])
                            int_next = 1'b1;
                    end

                    // a trigger from the previous tick takes effect now
                    if (trig_reg)
                    begin
                        mode_next = pending_mode;
                        trig_next = 1'b0;
                    end
                    if (step.hsync)
                    begin
                        if (mclk_reg < MCLK_FIRE)
                        begin
                            mclk_next = mclk_reg + MCLK_W'(1);
                            if (mclk_next == MCLK_FIRE)
                                trig_next = 1'b1;
                        end
                    end
                    else
                    begin
                        if (mclk_reg[2])
                            trig_next = 1'b1;
                        mclk_next = MCLK_RESET;
                    end

                    hs_prev_next = step.hsync;
                    vs_prev_next = step.vsync;
                end
                default:
                begin
                end
            endcase
        end
    end

    // int_asserted, active_mode, line_counter from the top bit down
    assign status = {int_reg, mode_reg, line_reg};

endmodule

`default_nettype wire

/* rtl/palette_register_and_raster_interrupt.sv */
// Top level: stream ports, input register, pen/border/mode/ROM registers.
// Depends on prri_pkg and prri_raster.
//
//  channel | dir | payload
//  s_*     | in  | tuser: func; tdata: write_byte, m1_n, iorq_n, hsync, vsync
//  m_*     | out | tdata: int, mode, lower/upper ROM, border, pen, colour, line
//
// A beat is captured in the input register and applied to the state registers once
// the result side can take it; one beat per cycle is sustained while m_tready is high.
// The state registers themselves form the result register, so a result is
// held while m_tready is low and the input register keeps one more beat.
// Reset: pens 0, border 16, both ROMs on, mode 0, counters idle.
`default_nettype none

module palette_register_and_raster_interrupt (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,  // write_byte[7:0], m1_n, iorq_n, hsync, vsync, zero fill
    input  wire logic [1:0]  s_tuser,  // func[1:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata   // int_asserted, active_mode[1:0], lower_rom_on,
                                       // upper_rom_on, border_colour[4:0], selected_pen[4:0],
                                       // pen_colour[4:0], line_counter[5:0], zero fill
);
    import prri_pkg::*;

    prri_step_t          in_reg;
    logic                out_valid_reg, out_valid_next;
    logic                advance;
    prri_step_t          step;
    prri_raster_t        raster;

    logic [COLOUR_W-1:0] pen_colours_reg [PEN_COUNT];
    logic [COLOUR_W-1:0] pen_sel_reg;
    logic [COLOUR_W-1:0] border_reg;
    logic [MODE_W-1:0]   pending_mode_reg;
    logic [1:0]          rom_reg;      // bit 0 lower on, bit 1 upper on
    logic [COLOUR_W-1:0] pen_colour;
    logic                pen_in_range;

    assign advance  = in_reg.valid && (!out_valid_reg || m_tready);
    assign s_tready = !in_reg.valid || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_reg <= '0;
        else
        begin
            if (s_tready)
                in_reg.valid <= s_tvalid;
            if (s_tready && s_tvalid)
            begin
                in_reg.func   <= prri_func_t'(s_tuser);
                in_reg.data   <= s_tdata[7:0];
                in_reg.m1_n   <= s_tdata[8];
                in_reg.iorq_n <= s_tdata[9];
                in_reg.hsync  <= s_tdata[10];
                in_reg.vsync  <= s_tdata[11];
            end
        end
    end

    always_comb
    begin
        if (advance)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_comb
    begin
        step       = in_reg;
        step.valid = advance;
    end

    assign pen_in_range = {1'b0, pen_sel_reg[3:0]} < 5'(PEN_COUNT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pen_sel_reg      <= '0;
            border_reg       <= BORDER_RESET;
            pending_mode_reg <= '0;
            rom_reg          <= 2'b11;
            for (int i = 0; i < PEN_COUNT; i++)
                pen_colours_reg[i] <= '0;
        end
        else if (advance && in_reg.func == FUNC_WRITE)
        begin
            unique case (prri_wr_t'(in_reg.data[7:6]))
                WR_PEN_SEL:
                    pen_sel_reg <= in_reg.data[4:0];
                WR_COLOUR:
                begin
                    if (pen_sel_reg[4])
                        border_reg <= in_reg.data[4:0];
                    else if (pen_in_range)
                        pen_colours_reg[pen_sel_reg[PEN_IDX_W-1:0]] <= in_reg.data[4:0];
                end
                WR_MODE_ROM:
                begin
                    pending_mode_reg <= in_reg.data[1:0];
                    rom_reg          <= {!in_reg.data[3], !in_reg.data[2]};
                end
                WR_MEM_MAP:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        if (pen_sel_reg[4])
            pen_colour = border_reg;
        else if (pen_in_range)
            pen_colour = pen_colours_reg[pen_sel_reg[PEN_IDX_W-1:0]];
        else
            pen_colour = '0;
    end

    prri_raster u_raster (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (step),
        .pending_mode (pending_mode_reg),
        .status       (raster)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'b0,
                       raster.line_counter,
                       pen_colour,
                       pen_sel_reg,
                       border_reg,
                       rom_reg[1],
                       rom_reg[0],
                       raster.active_mode,
                       raster.int_asserted};

    // counter never reaches the wrap value
    a_line_range: assert property (@(posedge clk) disable iff (!rst_n)
        raster.line_counter < LINES_WRAP)
        else $error("line counter out of range");

    // interrupt is raised only by a character tick
    a_int_rise: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(raster.int_asserted) |-> $past(advance && in_reg.func == FUNC_TICK))
        else $error("interrupt raised outside a character tick");

    // active mode changes only on a character tick
    a_mode_tick: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(raster.active_mode) |-> $past(advance && in_reg.func == FUNC_TICK))
        else $error("mode changed outside a character tick");

endmodule

`default_nettype wire

/* bench/palette_register_and_raster_interrupt_tb.sv */
`timescale 1ns / 100ps
// Self-checking bench for palette_register_and_raster_interrupt: drives register writes,
// interrupt acknowledges and CRTC character ticks and checks every result beat.
// Depends on prri_pkg and the RTL of the block; reads no files.

module palette_register_and_raster_interrupt_tb;
    import prri_pkg::*;

    localparam logic [1:0] FUNC_UNUSED = 2'd3;
    localparam int RANDOM_BEATS = 510;
    localparam int QUIET_AFTER  = 440;
    localparam int DRAIN_CYCLES = 8;
    localparam int RUN_LIMIT_NS = 2000000;

    // result beat as it sits in m_tdata[25:0], most significant field first
    typedef struct packed {
        logic [LINE_W-1:0]   line;
        logic [COLOUR_W-1:0] colour;
        logic [4:0]          pen;
        logic [COLOUR_W-1:0] border;
        logic                upper_rom;
        logic                lower_rom;
        logic [MODE_W-1:0]   mode;
        logic                irq;
    } gate_view_t;

    class gate_array_model;
        logic [4:0]          pen_sel;
        logic [COLOUR_W-1:0] pens [16];
        logic [COLOUR_W-1:0] border;
        logic [MODE_W-1:0]   pend_mode;
        logic [MODE_W-1:0]   cur_mode;
        logic                lower_on;
        logic                upper_on;
        logic                irq;
        logic [LINE_W-1:0]   lines;
        logic [RESYNC_W-1:0] resync;
        logic                ack_hold;
        logic [MCLK_W-1:0]   mclk;
        logic                mode_arm;
        logic                hs_prev;
        logic                vs_prev;
        gate_view_t          expected_views [$];
        int                  mismatches;
        int                  interrupts;
        int                  checked;

        function new();
            pen_sel   = '0;
            foreach (pens[i]) pens[i] = '0;
            border    = BORDER_RESET;
            pend_mode = '0;
            cur_mode  = '0;
            lower_on  = 1'b1;
            upper_on  = 1'b1;
            irq       = 1'b0;
            lines     = '0;
            resync    = '0;
            ack_hold  = 1'b0;
            mclk      = MCLK_RESET;
            mode_arm  = 1'b0;
            hs_prev   = 1'b0;
            vs_prev   = 1'b0;
            mismatches = 0;
            interrupts = 0;
            checked    = 0;
        endfunction

        // apply one accepted input beat and queue the view it leads to
        function void apply_beat(logic [1:0] kind, logic [15:0] d);
            logic [7:0]        b;
            logic              hs;
            logic              vs;
            logic              m1_low;
            logic              iorq_low;
            logic [LINE_W-1:0] old_lines;
            gate_view_t        v;
            b        = d[7:0];
            m1_low   = !d[8];
            iorq_low = !d[9];
            hs       = d[10];
            vs       = d[11];
            case (kind)
                FUNC_WRITE:
                    case (prri_wr_t'(b[7:6]))
                        WR_PEN_SEL: pen_sel = b[4:0];
                        WR_COLOUR:
                            if (pen_sel[4])
                                border = b[4:0];
                            else if (int'(pen_sel[3:0]) < PEN_COUNT)
                                pens[pen_sel[3:0]] = b[4:0];
                        WR_MODE_ROM:
                        begin
                            pend_mode = b[1:0];
                            lower_on  = !b[2];
                            upper_on  = !b[3];
                            if (b[4])
                            begin
                                irq   = 1'b0;
                                lines = '0;
                            end
                        end
                        default: ;
                    endcase
                FUNC_ACK:
                begin
                    if (m1_low && iorq_low && irq)
                        ack_hold = 1'b1;
                    else if (!m1_low)
                        ack_hold = 1'b0;
                    if (ack_hold)
                    begin
                        lines[5] = 1'b0;
                        irq      = 1'b0;
                    end
                end
                FUNC_TICK:
                begin
                    if (vs && !vs_prev)
                        resync = RESYNC_START;
                    // count a scan line on the hsync falling edge
                    if (!hs && hs_prev)
                    begin
                        old_lines = lines;
                        lines = lines + 1'b1;
                        if (lines == LINES_WRAP)
                            lines = '0;
                        if (resync < RESYNC_LIMIT)
                        begin
                            resync = resync + 1'b1;
                            if (resync == RESYNC_CLEAR)
                                lines = '0;
                        end
                        if (lines == '0 && old_lines[5])
                        begin
                            if (!irq)
                                interrupts++;
                            irq = 1'b1;
                        end
                    end
                    // mode latch armed on the previous tick
                    if (mode_arm)
                    begin
                        cur_mode = pend_mode;
                        mode_arm = 1'b0;
                    end
                    if (hs)
                    begin
                        if (mclk < MCLK_FIRE)
                        begin
                            mclk = mclk + 1'b1;
                            if (mclk == MCLK_FIRE)
                                mode_arm = 1'b1;
                        end
                    end
                    else
                    begin
                        if (mclk[2])
                            mode_arm = 1'b1;
                        mclk = MCLK_RESET;
                    end
                    hs_prev = hs;
                    vs_prev = vs;
                end
                default: ;
            endcase

            v.irq       = irq;
            v.mode      = cur_mode;
            v.lower_rom = lower_on;
            v.upper_rom = upper_on;
            v.border    = border;
            v.pen       = pen_sel;
            if (pen_sel[4])
                v.colour = border;
            else if (int'(pen_sel[3:0]) < PEN_COUNT)
                v.colour = pens[pen_sel[3:0]];
            else
                v.colour = '0;
            v.line = lines;
            expected_views.push_back(v);
        endfunction

        function void compare(string name, int unsigned want, int unsigned got);
            if (want != got)
            begin
                $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
                mismatches++;
            end
        endfunction

        function void check_view(logic [31:0] td);
            gate_view_t want;
            gate_view_t got;
            if (expected_views.size() == 0)
            begin
                $display("%0t: unexpected result beat, expected none, got %h", $time, td);
                mismatches++;
                return;
            end
            want = expected_views.pop_front();
            got  = td[25:0];
            checked++;
            compare("int_asserted", 32'(want.irq), 32'(got.irq));
            compare("active_mode", 32'(want.mode), 32'(got.mode));
            compare("lower_rom_on", 32'(want.lower_rom), 32'(got.lower_rom));
            compare("upper_rom_on", 32'(want.upper_rom), 32'(got.upper_rom));
            compare("border_colour", 32'(want.border), 32'(got.border));
            compare("selected_pen", 32'(want.pen), 32'(got.pen));
            compare("pen_colour", 32'(want.colour), 32'(got.colour));
            compare("line_counter", 32'(want.line), 32'(got.line));
            compare("tdata fill", 0, 32'(td[31:26]));
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;   // write_byte[7:0], m1_n, iorq_n, hsync, vsync, zero fill
    logic [1:0]  s_tuser;   // func[1:0]
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;   // int, mode[1:0], lower/upper ROM, border, pen, colour, line

    gate_array_model gate_model = new();
    bit quiet = 1'b0;
    int counted = 0;

    palette_register_and_raster_interrupt u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // called at a falling edge; returns at the falling edge after the beat is taken
    task automatic send_beat(input logic [1:0] kind, input logic [7:0] wr_byte,
                             input logic m1_n, input logic iorq_n,
                             input logic hs, input logic vs);
        logic [15:0] d;
        d = {4'b0000, vs, hs, iorq_n, m1_n, wr_byte};
        if (!quiet && $urandom_range(0, 7) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= d;
        do
            @(posedge clk);
        while (!s_tready);
        gate_model.apply_beat(kind, d);
        if (!(kind == FUNC_UNUSED || (kind == FUNC_WRITE && wr_byte[7:6] == WR_MEM_MAP)))
            counted++;
        @(negedge clk);
    endtask

    task automatic write_reg(input logic [7:0] wr_byte);
        send_beat(FUNC_WRITE, wr_byte, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    endtask

    task automatic ack(input logic m1_n, input logic iorq_n);
        send_beat(FUNC_ACK, 8'($urandom_range(0, 255)), m1_n, iorq_n,
                  1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    endtask

    task automatic tick(input logic hs, input logic vs);
        send_beat(FUNC_TICK, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)), hs, vs);
    endtask

    task automatic scan_line(input int high_ticks, input int low_ticks, input logic vs);
        repeat (high_ticks) tick(1'b1, vs);
        repeat (low_ticks) tick(1'b0, vs);
    endtask

    // result side: stall in bursts, accept otherwise
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!quiet && $urandom_range(0, 9) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(negedge clk);
            end
            m_tready <= 1'b1;
        end
    end

    always @(posedge clk)
        if (rst_n && m_tvalid && m_tready)
            gate_model.check_view(m_tdata);

    initial
    begin
        #(RUN_LIMIT_NS);
        $display("Timeout with %0d results outstanding", gate_model.expected_views.size());
        $display("Some tests failed");
        $finish;
    end

    initial
    begin
        int start_count;
        int pick;
        int line_in_frame;
        int frame_len;
        int hi;
        logic [7:0] b;

        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: reset view, unused kind, every write decode, acks, tick edges
        tick(1'b0, 1'b0);
        send_beat(FUNC_UNUSED, 8'hFF, 1'b0, 1'b0, 1'b1, 1'b1);
        write_reg(8'h00);
        write_reg(8'h5F);
        write_reg(8'h0F);
        write_reg(8'h55);
        write_reg(8'h1F);
        write_reg(8'h40);
        write_reg(8'h10);
        write_reg(8'h8F);
        write_reg(8'h80);
        write_reg(8'h9F);
        write_reg(8'hC0);
        write_reg(8'hFF);
        ack(1'b0, 1'b0);
        ack(1'b0, 1'b1);
        ack(1'b1, 1'b0);
        ack(1'b1, 1'b1);
        scan_line(7, 2, 1'b0);
        scan_line(4, 1, 1'b1);
        tick(1'b0, 1'b0);

        // random: raster lines framed by vsync, with writes, acks and noise mixed in
        start_count   = counted;
        line_in_frame = 0;
        frame_len     = $urandom_range(56, 120);
        while (counted - start_count < RANDOM_BEATS)
        begin
            quiet = (counted - start_count) > QUIET_AFTER;
            pick  = $urandom_range(0, 99);
            if (pick < 70)
            begin
                hi = ($urandom_range(0, 5) == 0) ? $urandom_range(3, 9) : 1;
                scan_line(hi, $urandom_range(1, 2), line_in_frame < 3);
                line_in_frame++;
                if (line_in_frame >= frame_len)
                begin
                    line_in_frame = 0;
                    frame_len     = $urandom_range(56, 120);
                end
                if (gate_model.irq && $urandom_range(0, 3) == 0)
                begin
                    ack(1'b0, 1'b0);
                    ack(1'b1, 1'($urandom_range(0, 1)));
                end
            end
            else if (pick < 82)
            begin
                b = 8'($urandom_range(0, 255));
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: b[7:6] = WR_PEN_SEL;
                    4, 5, 6:    b[7:6] = WR_COLOUR;
                    7, 8:
                    begin
                        b[7:6] = WR_MODE_ROM;
                        b[4]   = ($urandom_range(0, 4) == 0);
                    end
                    default:    b[7:6] = WR_MEM_MAP;
                endcase
                write_reg(b);
            end
            else if (pick < 90)
            begin
                ack(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                ack(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            end
            else if (pick < 97)
                tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            else
                send_beat(FUNC_UNUSED, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                          1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                          1'($urandom_range(0, 1)));
        end
        s_tvalid <= 1'b0;

        while (gate_model.expected_views.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d state-changing beats and %0d checked results,",
                 counted, gate_model.checked);
        $display("with %0d raster interrupts raised over the run.", gate_model.interrupts);
        if (gate_model.mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

/* palette_register_and_raster_interrupt.f */
rtl/prri_pkg.sv
rtl/prri_raster.sv
rtl/palette_register_and_raster_interrupt.sv
bench/palette_register_and_raster_interrupt_tb.sv
